>>> design/pmsfr_pkg.sv
// Shared types and constants for the particulate-sensor frame receiver.
package pmsfr_pkg;

    // Input item command codes.
    typedef enum logic [2:0] {
        CMD_RX_BYTE = 3'd0,
        CMD_TICK    = 3'd1,
        CMD_POLL    = 3'd2,
        CMD_START   = 3'd3,
        CMD_STOP    = 3'd4
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SLEEP_TICK    = 3'd0,
        REG_WAKE_TICK     = 3'd1,
        REG_FAULT_LIMIT   = 3'd2,
        REG_RESTART_LIMIT = 3'd3,
        REG_FAULT_READING = 3'd4,
        REG_START_READING = 3'd5
    } reg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Frame header bytes.
    localparam logic [7:0] HDR0 = 8'h42;
    localparam logic [7:0] HDR1 = 8'h4D;

    // Reset values of the configuration registers and of the reading.
    localparam logic [9:0]  SLEEP_TICK_RST    = 10'd400;
    localparam logic [9:0]  WAKE_TICK_RST     = 10'd700;
    localparam logic [4:0]  FAULT_LIMIT_RST   = 5'd10;
    localparam logic [4:0]  RESTART_LIMIT_RST = 5'd20;
    localparam logic [15:0] FAULT_READING_RST = 16'd1000;
    localparam logic [15:0] START_READING_RST = 16'd100;
    localparam logic [15:0] READING_RST       = 16'd50;

    // Poll count saturates here.
    localparam logic [4:0]  POLL_MAX = 5'd31;

    // Configuration register set.
    typedef struct packed {
        logic [9:0]  sleep_tick;
        logic [9:0]  wake_tick;
        logic [4:0]  fault_limit;
        logic [4:0]  restart_limit;
        logic [15:0] fault_reading;
        logic [15:0] start_reading;
    } cfg_t;

    // Outcome of one received byte from the frame parser.
    typedef struct packed {
        logic        good;
        logic        bad;
        logic [15:0] reading;
    } frame_result_t;

    // Sensor control levels and the current reading.
    typedef struct packed {
        logic [15:0] reading;
        logic        awake;
        logic        fan;
        logic        rx_on;
    } sensor_status_t;

endpackage

>>> design/pmsfr_frame_parser.sv
// Frame parser: header check, running checksum and capture of the PM2.5 bytes.
module pmsfr_frame_parser
    import pmsfr_pkg::*;
#(
    parameter int FRAME_BYTES = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_en,
    input  logic [7:0]    rx_byte,
    output frame_result_t result
);

    localparam int PW = $clog2(FRAME_BYTES);
    localparam logic [PW-1:0] POS_HDR1     = PW'(1);
    localparam logic [PW-1:0] POS_RD_HIGH  = PW'(6);
    localparam logic [PW-1:0] POS_RD_LOW   = PW'(7);
    localparam logic [PW-1:0] POS_CHK_HIGH = PW'(FRAME_BYTES - 2);

    logic [PW-1:0] pos_reg, pos_next;
    logic [15:0]   sum_reg, sum_next;
    logic [15:0]   pending_reg, pending_next;
    logic [7:0]    check_high_reg, check_high_next;
    logic [15:0]   pending_upd;

    // The reading bytes are captured before the position decision, so a frame
    // that ends on the low reading byte already sees the new value.
    always_comb
    begin
        pending_upd = pending_reg;
        if (pos_reg == POS_RD_HIGH)
        begin
            pending_upd = {rx_byte, 8'h00};
        end
        else if (pos_reg == POS_RD_LOW)
        begin
            pending_upd = {pending_reg[15:8], rx_byte};
        end
    end

    // Next position, checksum and frame outcome.
    always_comb
    begin
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        pending_next    = pending_reg;
        check_high_next = check_high_reg;
        result.good     = 1'b0;
        result.bad      = 1'b0;
        result.reading  = pending_upd;
        if (byte_en)
        begin
            pending_next = pending_upd;
            if (pos_reg == '0)
            begin
                if (rx_byte == HDR0)
                begin
                    sum_next = {8'h00, rx_byte};
                    pos_next = POS_HDR1;
                end
                else
                begin
                    sum_next = '0;
                    pos_next = '0;
                end
            end
            else if (pos_reg == POS_HDR1)
            begin
                if (rx_byte == HDR1)
                begin
                    sum_next = sum_reg + {8'h00, rx_byte};
                    pos_next = pos_reg + PW'(1);
                end
                else
                begin
                    sum_next = '0;
                    pos_next = '0;
                end
            end
            else if (pos_reg < POS_CHK_HIGH)
            begin
                sum_next = sum_reg + {8'h00, rx_byte};
                pos_next = pos_reg + PW'(1);
            end
            else if (pos_reg == POS_CHK_HIGH)
            begin
                check_high_next = rx_byte;
                pos_next        = pos_reg + PW'(1);
            end
            else
            begin
                if ({check_high_reg, rx_byte} == sum_reg)
                begin
                    result.good = 1'b1;
                end
                else
                begin
                    result.bad = 1'b1;
                end
                sum_next = '0;
                pos_next = '0;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            sum_reg        <= '0;
            pending_reg    <= '0;
            check_high_reg <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            pending_reg    <= pending_next;
            check_high_reg <= check_high_next;
        end
    end

endmodule

>>> design/pmsfr_sensor_ctrl.sv
// Sensor control: duty-cycle timer, poll fault count, start and stop commands.
module pmsfr_sensor_ctrl
    import pmsfr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step_en,
    input  logic [2:0]     command,
    input  cfg_t           cfg,
    input  frame_result_t  frame,
    output sensor_status_t status_cur,
    output sensor_status_t status_next
);

    logic [15:0] reading_reg, reading_next;
    logic [4:0]  poll_reg, poll_next;
    logic        duty_reg, duty_next;
    logic [9:0]  tick_reg, tick_next;
    logic        wake_reg, wake_next;
    logic        fan_reg, fan_next;
    logic        rx_reg, rx_next;

    // Next state for one item.
    always_comb
    begin
        reading_next = reading_reg;
        poll_next    = poll_reg;
        duty_next    = duty_reg;
        tick_next    = tick_reg;
        wake_next    = wake_reg;
        fan_next     = fan_reg;
        rx_next      = rx_reg;
        if (step_en)
        begin
            case (cmd_t'(command))
                CMD_RX_BYTE:
                begin
                    if (frame.good)
                    begin
                        reading_next = frame.reading;
                        poll_next    = '0;
                    end
                end
                CMD_TICK:
                begin
                    if (duty_reg)
                    begin
                        tick_next = tick_reg + 10'd1;
                        if (tick_next == cfg.sleep_tick)
                        begin
                            wake_next = 1'b0;
                        end
                        else if (tick_next > cfg.wake_tick)
                        begin
                            tick_next = '0;
                            wake_next = 1'b1;
                        end
                    end
                end
                CMD_POLL:
                begin
                    if (poll_reg > cfg.fault_limit)
                    begin
                        if ({1'b0, poll_reg} == {1'b0, cfg.fault_limit} + 6'd1)
                        begin
                            fan_next  = 1'b0;
                            wake_next = 1'b0;
                            duty_next = 1'b0;
                            rx_next   = 1'b0;
                        end
                        else if (poll_reg > cfg.restart_limit)
                        begin
                            fan_next  = 1'b1;
                            rx_next   = 1'b1;
                            wake_next = 1'b1;
                            tick_next = '0;
                            duty_next = 1'b1;
                            poll_next = '0;
                        end
                        reading_next = cfg.fault_reading;
                    end
                    if (poll_next < POLL_MAX)
                    begin
                        poll_next = poll_next + 5'd1;
                    end
                end
                CMD_START:
                begin
                    fan_next     = 1'b1;
                    rx_next      = 1'b1;
                    wake_next    = 1'b1;
                    tick_next    = '0;
                    duty_next    = 1'b1;
                    poll_next    = '0;
                    reading_next = cfg.start_reading;
                end
                CMD_STOP:
                begin
                    fan_next  = 1'b0;
                    wake_next = 1'b0;
                    duty_next = 1'b0;
                    rx_next   = 1'b0;
                end
                default:
                begin
                    reading_next = reading_reg;
                end
            endcase
        end
    end

    // Status views before and after the item.
    always_comb
    begin
        status_cur.reading  = reading_reg;
        status_cur.awake    = wake_reg;
        status_cur.fan      = fan_reg;
        status_cur.rx_on    = rx_reg;
        status_next.reading = reading_next;
        status_next.awake   = wake_next;
        status_next.fan     = fan_next;
        status_next.rx_on   = rx_next;
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_reg <= READING_RST;
            poll_reg    <= '0;
            duty_reg    <= 1'b0;
            tick_reg    <= '0;
            wake_reg    <= 1'b0;
            fan_reg     <= 1'b0;
            rx_reg      <= 1'b1;
        end
        else
        begin
            reading_reg <= reading_next;
            poll_reg    <= poll_next;
            duty_reg    <= duty_next;
            tick_reg    <= tick_next;
            wake_reg    <= wake_next;
            fan_reg     <= fan_next;
            rx_reg      <= rx_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A good frame leaves the poll count cleared.
    a_good_clears_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && frame.good) |=> (poll_reg == '0))
        else $error("poll count not cleared after good frame");

    // Ticks while the duty cycle is stopped leave the timer alone.
    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && command == CMD_TICK && !duty_reg) |=> $stable(tick_reg))
        else $error("tick counter moved while stopped");
`endif

endmodule

>>> design/pm_sensor_frame_receiver_top.sv
// Top level: input register, frame parser, sensor control and result register.
// An accepted item is held in the input register; when the result register is
// free or being taken, the state after the item is written into it.
// Throughput: one item per cycle unless the result register is stalled; each
// item is handled between the input and result registers with a running checksum.
// Reset (rst_n, asynchronous, active low) restores the control state, valid flags
// and configuration defaults at once; no clearing pass is needed.
module pm_sensor_frame_receiver_top
    import pmsfr_pkg::*;
#(
    parameter int FRAME_BYTES = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             command,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [15:0]            reading,
    output logic                   frame_good,
    output logic                   frame_bad,
    output logic                   sensor_awake,
    output logic                   fan_on,
    output logic                   receiver_on
);

    cfg_t           cfg_reg;
    logic           in_valid_reg;
    logic [2:0]     command_reg;
    logic [7:0]     rx_byte_reg;
    logic           out_valid_reg;
    logic [15:0]    reading_reg;
    logic           frame_good_reg;
    logic           frame_bad_reg;
    logic           awake_reg;
    logic           fan_reg;
    logic           rx_on_reg;
    logic           advance;
    logic           byte_en;
    frame_result_t  frame;
    sensor_status_t status_cur;
    sensor_status_t status_next;

    // The held item moves on when the result register is free or being taken.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign byte_en  = advance && (command_reg == CMD_RX_BYTE) && status_cur.rx_on;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sleep_tick    <= SLEEP_TICK_RST;
            cfg_reg.wake_tick     <= WAKE_TICK_RST;
            cfg_reg.fault_limit   <= FAULT_LIMIT_RST;
            cfg_reg.restart_limit <= RESTART_LIMIT_RST;
            cfg_reg.fault_reading <= FAULT_READING_RST;
            cfg_reg.start_reading <= START_READING_RST;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_SLEEP_TICK:    cfg_reg.sleep_tick    <= cfg_data[9:0];
                REG_WAKE_TICK:     cfg_reg.wake_tick     <= cfg_data[9:0];
                REG_FAULT_LIMIT:   cfg_reg.fault_limit   <= cfg_data[4:0];
                REG_RESTART_LIMIT: cfg_reg.restart_limit <= cfg_data[4:0];
                REG_FAULT_READING: cfg_reg.fault_reading <= cfg_data;
                REG_START_READING: cfg_reg.start_reading <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register: item payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            command_reg <= command;
            rx_byte_reg <= rx_byte;
        end
    end

    pmsfr_frame_parser #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .rx_byte (rx_byte_reg),
        .result  (frame)
    );

    pmsfr_sensor_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .command     (command_reg),
        .cfg         (cfg_reg),
        .frame       (frame),
        .status_cur  (status_cur),
        .status_next (status_next)
    );

    // Result register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register: item payload, the state after the item.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            reading_reg    <= status_next.reading;
            frame_good_reg <= frame.good && byte_en;
            frame_bad_reg  <= frame.bad && byte_en;
            awake_reg      <= status_next.awake;
            fan_reg        <= status_next.fan;
            rx_on_reg      <= status_next.rx_on;
        end
    end

    assign out_valid    = out_valid_reg;
    assign reading      = reading_reg;
    assign frame_good   = frame_good_reg;
    assign frame_bad    = frame_bad_reg;
    assign sensor_awake = awake_reg;
    assign fan_on       = fan_reg;
    assign receiver_on  = rx_on_reg;

`ifndef NO_ASSERTIONS
    // A frame is either good or bad, never both.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(frame_good_reg && frame_bad_reg))
        else $error("frame reported both good and bad");

    // A byte taken while the receiver is off completes no frame.
    a_rx_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && command_reg == CMD_RX_BYTE && !status_cur.rx_on)
        |=> (!frame_good_reg && !frame_bad_reg))
        else $error("frame flag raised while receiver off");

    // Back-pressure only arises from a held item that cannot move on.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without cause");
`endif

endmodule

>>> tb/pm_sensor_frame_receiver_top_tb.sv
// Self-checking testbench for the particulate-sensor frame receiver top level.
`timescale 1ns / 100ps

module pm_sensor_frame_receiver_top_tb
    import pmsfr_pkg::*;
();

    localparam int FRAME_LEN     = 32;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    // Command codes that the block does not decode.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    // One input item as queued for the driver.
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] rx_byte;
    } sensor_item_t;

    // One result item as the block should present it.
    typedef struct packed {
        logic [15:0] reading;
        logic        frame_good;
        logic        frame_bad;
        logic        awake;
        logic        fan;
        logic        rx_on;
    } sensor_report_t;

    // Ways in which a generated frame can be spoilt.
    typedef enum int {
        FRAME_CLEAN,
        FRAME_BAD_SUM,
        FRAME_BAD_HDR0,
        FRAME_BAD_HDR1,
        FRAME_CUT
    } frame_flaw_t;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic [2:0]             command    = 3'd0;
    logic [7:0]             rx_byte    = 8'h00;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [15:0]            reading;
    logic                   frame_good;
    logic                   frame_bad;
    logic                   sensor_awake;
    logic                   fan_on;
    logic                   receiver_on;

    // Items waiting to be offered, and the reports predicted for accepted items.
    sensor_item_t   cmd_backlog[$];
    sensor_report_t predicted_reports[$];

    // Predictor copy of the configuration and of the block state.
    cfg_t        sensor_cfg;
    logic [4:0]  frame_pos;
    logic [15:0] frame_sum;
    logic [15:0] frame_pm;
    logic [7:0]  sum_hi;
    logic [15:0] pm_now;
    logic [4:0]  polls;
    logic        duty_on;
    logic [9:0]  ticks;
    logic        wake_pin;
    logic        fan_pin;
    logic        rx_on;

    int error_count   = 0;
    int counted_items = 0;
    int idle_cycles   = 0;

    // Driver and monitor working variables.
    int             burst_left = 0;
    int             gap_left   = 0;
    logic           offer_next;
    sensor_item_t   next_item;
    sensor_report_t wanted;
    int             stall_mode  = 0;
    int             mode_left   = 0;
    logic [7:0]     stall_phase = 8'd0;

    pm_sensor_frame_receiver_top #(
        .FRAME_BYTES(FRAME_LEN)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .reading      (reading),
        .frame_good   (frame_good),
        .frame_bad    (frame_bad),
        .sensor_awake (sensor_awake),
        .fan_on       (fan_on),
        .receiver_on  (receiver_on)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Sensor start actions, shared by the start command and the poll restart.
    task automatic sensor_wake_up();
        fan_pin  = 1'b1;
        rx_on    = 1'b1;
        wake_pin = 1'b1;
        ticks    = 10'd0;
        duty_on  = 1'b1;
        polls    = 5'd0;
        pm_now   = sensor_cfg.start_reading;
    endtask

    task automatic sensor_shut_down();
        fan_pin  = 1'b0;
        wake_pin = 1'b0;
        duty_on  = 1'b0;
        rx_on    = 1'b0;
    endtask

    // Advances the predicted sensor state by one item and queues the report.
    task automatic advance_sensor(input logic [2:0] cmd, input logic [7:0] b);
        sensor_report_t rep;
        logic           good;
        logic           bad;
        good = 1'b0;
        bad  = 1'b0;
        case (cmd)
            CMD_RX_BYTE:
            begin
                if (rx_on)
                begin
                    // The reading bytes are captured before the position moves on.
                    if (frame_pos == 5'd6)
                        frame_pm = {b, 8'h00};
                    if (frame_pos == 5'd7)
                        frame_pm[7:0] = b;
                    if (frame_pos == 5'd0)
                    begin
                        if (b == HDR0)
                        begin
                            frame_sum = {8'h00, b};
                            frame_pos = 5'd1;
                        end
                        else
                        begin
                            frame_sum = 16'd0;
                            frame_pos = 5'd0;
                        end
                    end
                    else if (frame_pos == 5'd1)
                    begin
                        if (b == HDR1)
                        begin
                            frame_sum = frame_sum + {8'h00, b};
                            frame_pos = 5'd2;
                        end
                        else
                        begin
                            frame_sum = 16'd0;
                            frame_pos = 5'd0;
                        end
                    end
                    else if (int'(frame_pos) < FRAME_LEN - 2)
                    begin
                        frame_sum = frame_sum + {8'h00, b};
                        frame_pos = frame_pos + 5'd1;
                    end
                    else if (int'(frame_pos) == FRAME_LEN - 2)
                    begin
                        sum_hi    = b;
                        frame_pos = frame_pos + 5'd1;
                    end
                    else
                    begin
                        if ({sum_hi, b} == frame_sum)
                        begin
                            pm_now = frame_pm;
                            polls  = 5'd0;
                            good   = 1'b1;
                        end
                        else
                            bad = 1'b1;
                        frame_sum = 16'd0;
                        frame_pos = 5'd0;
                    end
                end
            end
            CMD_TICK:
            begin
                if (duty_on)
                begin
                    ticks = ticks + 10'd1;
                    if (ticks == sensor_cfg.sleep_tick)
                        wake_pin = 1'b0;
                    else if (ticks > sensor_cfg.wake_tick)
                    begin
                        ticks    = 10'd0;
                        wake_pin = 1'b1;
                    end
                end
            end
            CMD_POLL:
            begin
                if (polls > sensor_cfg.fault_limit)
                begin
                    if ({1'b0, polls} == {1'b0, sensor_cfg.fault_limit} + 6'd1)
                        sensor_shut_down();
                    else if (polls > sensor_cfg.restart_limit)
                        sensor_wake_up();
                    pm_now = sensor_cfg.fault_reading;
                end
                if (polls < POLL_MAX)
                    polls = polls + 5'd1;
            end
            CMD_START:
                sensor_wake_up();
            CMD_STOP:
                sensor_shut_down();
            default:
            begin
            end
        endcase
        rep.reading    = pm_now;
        rep.frame_good = good;
        rep.frame_bad  = bad;
        rep.awake      = wake_pin;
        rep.fan        = fan_pin;
        rep.rx_on      = rx_on;
        predicted_reports.push_back(rep);
    endtask

    task automatic queue_item(input logic [2:0] cmd, input logic [7:0] b);
        sensor_item_t it;
        it.command = cmd;
        it.rx_byte = b;
        cmd_backlog.push_back(it);
        if (cmd <= CMD_STOP)
            counted_items++;
    endtask

    // Queues one frame, now and then with a tick or a poll slipped between bytes.
    task automatic queue_frame(input frame_flaw_t flaw);
        logic [7:0]  body [FRAME_LEN];
        logic [15:0] sum;
        int          i;
        int          stop_at;
        body[0] = HDR0;
        body[1] = HDR1;
        for (i = 2; i < FRAME_LEN - 2; i++)
            body[i] = 8'($urandom_range(0, 255));
        sum = 16'd0;
        for (i = 0; i < FRAME_LEN - 2; i++)
            sum = sum + {8'h00, body[i]};
        if (flaw == FRAME_BAD_SUM)
            sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
        body[FRAME_LEN - 2] = sum[15:8];
        body[FRAME_LEN - 1] = sum[7:0];
        if (flaw == FRAME_BAD_HDR0)
        begin
            do
                body[0] = 8'($urandom_range(0, 255));
            while (body[0] == HDR0);
        end
        if (flaw == FRAME_BAD_HDR1)
        begin
            do
                body[1] = 8'($urandom_range(0, 255));
            while (body[1] == HDR1);
        end
        stop_at = (flaw == FRAME_CUT) ? $urandom_range(2, FRAME_LEN - 1) : FRAME_LEN;
        for (i = 0; i < stop_at; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                queue_item($urandom_range(0, 1) ? CMD_TICK : CMD_POLL,
                           8'($urandom_range(0, 255)));
            queue_item(CMD_RX_BYTE, body[i]);
        end
    endtask

    // Returns once no item is queued, offered or awaiting its report.
    task automatic wait_for_quiet();
        while (cmd_backlog.size() != 0 || in_valid || predicted_reports.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_SLEEP_TICK:    sensor_cfg.sleep_tick    = value[9:0];
            REG_WAKE_TICK:     sensor_cfg.wake_tick     = value[9:0];
            REG_FAULT_LIMIT:   sensor_cfg.fault_limit   = value[4:0];
            REG_RESTART_LIMIT: sensor_cfg.restart_limit = value[4:0];
            REG_FAULT_READING: sensor_cfg.fault_reading = value;
            REG_START_READING: sensor_cfg.start_reading = value;
            default:
            begin
            end
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] sleep_v, input logic [15:0] wake_v,
                                  input logic [15:0] fault_v, input logic [15:0] restart_v,
                                  input logic [15:0] fault_rd, input logic [15:0] start_rd);
        write_reg(REG_SLEEP_TICK, sleep_v);
        write_reg(REG_WAKE_TICK, wake_v);
        write_reg(REG_FAULT_LIMIT, fault_v);
        write_reg(REG_RESTART_LIMIT, restart_v);
        write_reg(REG_FAULT_READING, fault_rd);
        write_reg(REG_START_READING, start_rd);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random traffic: mostly frames, with bursts of ticks and polls and some noise.
    task automatic queue_random_traffic(input int quota);
        int first;
        int pick;
        int n;
        first = counted_items;
        while (counted_items - first < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 44)
                queue_frame(FRAME_CLEAN);
            else if (pick < 50)
                queue_frame(frame_flaw_t'($urandom_range(1, 4)));
            else if (pick < 62)
            begin
                n = $urandom_range(1, 40);
                repeat (n) queue_item(CMD_TICK, 8'($urandom_range(0, 255)));
            end
            else if (pick < 73)
            begin
                n = $urandom_range(1, 35);
                repeat (n) queue_item(CMD_POLL, 8'($urandom_range(0, 255)));
            end
            else if (pick < 80)
                queue_item(CMD_START, 8'($urandom_range(0, 255)));
            else if (pick < 84)
                queue_item(CMD_STOP, 8'($urandom_range(0, 255)));
            else if (pick < 93)
            begin
                // Loose bytes, often header values, to upset the header search.
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    case ($urandom_range(0, 3))
                        0: queue_item(CMD_RX_BYTE, HDR0);
                        1: queue_item(CMD_RX_BYTE, HDR1);
                        default: queue_item(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
                    endcase
                end
            end
            else if (pick < 97)
                queue_item(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                           8'($urandom_range(0, 255)));
            else
                // Hold the sender back until every outstanding report is in.
                wait_for_quiet();
        end
    endtask

    // Driver: offers queued items in bursts and predicts each accepted item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            command    <= CMD_RX_BYTE;
            rx_byte    <= 8'h00;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            offer_next = in_valid;
            if (in_valid && in_ready)
            begin
                advance_sensor(command, rx_byte);
                offer_next = 1'b0;
            end
            if (!offer_next)
            begin
                if (gap_left > 0)
                    gap_left = gap_left - 1;
                else if (cmd_backlog.size() > 0)
                begin
                    next_item = cmd_backlog.pop_front();
                    command   <= next_item.command;
                    rx_byte   <= next_item.rx_byte;
                    offer_next = 1'b1;
                    if (burst_left > 0)
                        burst_left = burst_left - 1;
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            in_valid <= offer_next;
        end
    end

    // Monitor: checks each accepted result and drives its own stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_mode  <= 0;
            mode_left   <= 0;
            stall_phase <= 8'd0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_reports.size() == 0)
                begin
                    if (error_count < REPORT_LIMIT)
                        $display("unexpected result: reading=%0d good=%0b bad=%0b",
                                 reading, frame_good, frame_bad);
                    error_count++;
                end
                else
                begin
                    wanted = predicted_reports.pop_front();
                    if (wanted.reading !== reading || wanted.frame_good !== frame_good ||
                        wanted.frame_bad !== frame_bad || wanted.awake !== sensor_awake ||
                        wanted.fan !== fan_on || wanted.rx_on !== receiver_on)
                    begin
                        if (error_count < REPORT_LIMIT)
                            $display("mismatch at %0t: expected reading=%0d good=%0b ",
                                     $realtime, wanted.reading, wanted.frame_good,
                                     "bad=%0b awake=%0b fan=%0b rx=%0b, ",
                                     wanted.frame_bad, wanted.awake, wanted.fan,
                                     wanted.rx_on,
                                     "got reading=%0d good=%0b bad=%0b ",
                                     reading, frame_good, frame_bad,
                                     "awake=%0b fan=%0b rx=%0b",
                                     sensor_awake, fan_on, receiver_on);
                        error_count++;
                    end
                end
            end
            // Stall pattern: always ready, three in four, coin toss, or one in eight.
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(32, 256);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= (stall_phase[1:0] != 2'd0);
                2: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= (stall_phase[2:0] == 3'd0);
            endcase
            stall_phase <= stall_phase + 8'd1;
        end
    end

    // Watchdog: ends the run if nothing moves on either side for too long.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus: reset, directed items, then phases of settings and random traffic.
    initial
    begin
        sensor_cfg.sleep_tick    = SLEEP_TICK_RST;
        sensor_cfg.wake_tick     = WAKE_TICK_RST;
        sensor_cfg.fault_limit   = FAULT_LIMIT_RST;
        sensor_cfg.restart_limit = RESTART_LIMIT_RST;
        sensor_cfg.fault_reading = FAULT_READING_RST;
        sensor_cfg.start_reading = START_READING_RST;
        frame_pos = 5'd0;
        frame_sum = 16'd0;
        frame_pm  = 16'd0;
        sum_hi    = 8'd0;
        pm_now    = READING_RST;
        polls     = 5'd0;
        duty_on   = 1'b0;
        ticks     = 10'd0;
        wake_pin  = 1'b0;
        fan_pin   = 1'b0;
        rx_on     = 1'b1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bytes that fail the header search at either position.
        queue_item(CMD_RX_BYTE, 8'h00);
        queue_item(CMD_RX_BYTE, 8'hFF);
        queue_item(CMD_RX_BYTE, HDR0);
        queue_item(CMD_RX_BYTE, HDR0);
        // A good header, left open while other commands pass.
        queue_item(CMD_RX_BYTE, HDR0);
        queue_item(CMD_RX_BYTE, HDR1);
        queue_item(CMD_SPARE_FIRST, 8'hFF);
        queue_item(CMD_SPARE_FIRST + 3'd1, 8'h00);
        queue_item(CMD_SPARE_LAST, 8'hA5);
        // A tick and a poll while the sensor is stopped.
        queue_item(CMD_TICK, 8'h00);
        queue_item(CMD_POLL, 8'hFF);
        queue_item(CMD_STOP, 8'h00);
        // The receiver is off, so this byte is ignored.
        queue_item(CMD_RX_BYTE, 8'h55);
        queue_item(CMD_STOP, 8'hFF);
        queue_item(CMD_START, 8'h00);
        queue_item(CMD_RX_BYTE, 8'hFF);
        queue_item(CMD_RX_BYTE, 8'h00);
        queue_item(CMD_TICK, 8'hFF);
        queue_item(CMD_TICK, 8'h5A);
        queue_item(CMD_POLL, 8'h00);
        queue_item(CMD_START, 8'hFF);
        // Enough ticks to pass both default duty-cycle thresholds.
        repeat (720) queue_item(CMD_TICK, 8'($urandom_range(0, 255)));
        queue_random_traffic(80);
        wait_for_quiet();

        // Lowest thresholds and extreme readings.
        apply_settings(16'd1, 16'd1, 16'd1, 16'd1, 16'h0000, 16'hFFFF);
        queue_random_traffic(60);
        wait_for_quiet();

        // High thresholds; a long tick run wraps the tick counter.
        apply_settings(16'd1023, 16'd1023, 16'd30, 16'd30, 16'hFFFF, 16'h0000);
        queue_item(CMD_START, 8'($urandom_range(0, 255)));
        repeat (1030) queue_item(CMD_TICK, 8'($urandom_range(0, 255)));
        queue_random_traffic(30);
        wait_for_quiet();

        // Restart below the fault limit, with small tick thresholds.
        apply_settings(16'd5, 16'd12, 16'd8, 16'd3, 16'($urandom_range(0, 16'hFFFF)),
                       16'($urandom_range(0, 16'hFFFF)));
        queue_random_traffic(60);
        wait_for_quiet();

        // Whole 16-bit words, of which the narrower registers keep only the low bits.
        apply_settings(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                       16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                       16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
        queue_random_traffic(60);
        wait_for_quiet();

        // Random settings within range, small tick thresholds.
        repeat (2)
        begin
            apply_settings(16'($urandom_range(1, 40)), 16'($urandom_range(1, 60)),
                           16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)),
                           16'($urandom_range(0, 16'hFFFF)),
                           16'($urandom_range(0, 16'hFFFF)));
            queue_random_traffic(50);
            wait_for_quiet();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && predicted_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
